FILE: rtl/core/ftc_pkg.sv
// ----------------------------------------------------------------------------
// Fan temperature control loop package
// Shared widths, register codes, control constants and the queue item type.
// ----------------------------------------------------------------------------
package ftc_pkg;

  // Field and register widths
  localparam int ADC_W       = 10;
  localparam int SUM_W       = 14;
  localparam int GOAL_W      = 8;
  localparam int GAIN_W      = 4;
  localparam int DUTY_W      = 10;
  localparam int TEMP_W      = 9;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 1;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GOAL_TEMP = 1'b0,
    REG_LOOP_GAIN = 1'b1
  } cfg_reg_t;

  localparam logic [GOAL_W-1:0] GOAL_RESET = 8'd40;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd5;

  // Parameter defaults
  localparam int AVG_COUNT_DEFAULT   = 10;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Conversion to degrees: (avg * 330) >> 10
  localparam int                TEMP_SCALE_W = 9;
  localparam logic [8:0]        TEMP_SCALE   = 9'd330;
  localparam int                TEMP_SHIFT   = 10;

  // Duty map breakpoints and segment coefficients
  localparam int         DUTY_OFF_T = 76;
  localparam int         DUTY_MID_T = 31;
  localparam int         DUTY_LOW_T = 20;
  localparam int         SLOPE_W    = 7;
  localparam logic [6:0] MID_SLOPE  = 7'd84;
  localparam logic [6:0] LOW_SLOPE  = 7'd49;
  localparam logic [7:0] MID_BASE   = 8'd63;
  localparam logic [7:0] LOW_BASE   = 8'd187;
  localparam logic [6:0] MID_DIV    = 7'd100;
  localparam logic [6:0] LOW_DIV    = 7'd10;
  localparam logic [6:0] PCT_MAX    = 7'd100;
  localparam logic [3:0] PCT_SCALE  = 4'd10;

  // Finished sum handed from front to back
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } sum_item_t;

endpackage

FILE: rtl/core/ftc_front.sv
// ----------------------------------------------------------------------------
// Fan temperature control front end
// Accepts samples, accumulates the averaging window and pushes each finished
// sum into the queue when the trigger sample arrives.
// ----------------------------------------------------------------------------
module ftc_front import ftc_pkg::*; #(
  parameter int AVG_COUNT = AVG_COUNT_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  logic [ADC_W-1:0] adc_sample,
  input  logic             queue_full,
  output sum_item_t        push
);

  localparam int                CNT_W   = $clog2(AVG_COUNT + 1);
  localparam logic [CNT_W-1:0]  CNT_END = CNT_W'(AVG_COUNT);

  logic [SUM_W-1:0] sample_sum;
  logic [CNT_W-1:0] sample_count;
  logic             accept;
  logic             trigger;

  // Hold off new samples while the queue has no room
  assign sample_stall = queue_full;
  assign accept       = sample_valid && !queue_full;
  assign trigger      = (sample_count == CNT_END);

  assign push.valid = accept && trigger;
  assign push.sum   = sample_sum;

  // Accumulate the window; the trigger sample is dropped and restarts it
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (trigger) begin
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sample_sum + SUM_W'(adc_sample);
        sample_count <= sample_count + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/ftc_queue.sv
// ----------------------------------------------------------------------------
// Fan temperature control sum queue
// Short FIFO of window sums between the front end and the update sequencer.
// ----------------------------------------------------------------------------
module ftc_queue import ftc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  sum_item_t push,
  output logic      full,
  output sum_item_t pop,
  input  logic      pop_stall
);

  localparam int               PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int               FILL_W  = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_END = PTR_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

  logic [SUM_W-1:0]  entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full      = (fill == FILL_MAX);
  assign pop.valid = (fill != '0);
  assign pop.sum   = entries[rd_ptr];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop.valid && !pop_stall;

  // Store pushed sums
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.sum;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_END) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_END) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: rtl/core/ftc_back.sv
// ----------------------------------------------------------------------------
// Fan temperature control update sequencer
// Turns one window sum into a temperature and a duty compare value over a
// fixed sequence of steps, one multiply per step, and holds the result in an
// output register until it is taken.
// ----------------------------------------------------------------------------
module ftc_back import ftc_pkg::*; #(
  parameter int AVG_COUNT = AVG_COUNT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [GOAL_W-1:0] goal_temp,
  input  logic [GAIN_W-1:0] loop_gain,
  input  sum_item_t         pop,
  output logic              pop_stall,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [DUTY_W-1:0] duty_count,
  output logic [TEMP_W-1:0] temperature
);

  // Averaging divide by reciprocal multiply plus one correction
  localparam int                     CNT_W       = $clog2(AVG_COUNT + 1);
  localparam int                     AVG_SHIFT   = 18;
  localparam int                     AVG_RECIP_W = AVG_SHIFT + 1;
  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP   = AVG_RECIP_W'((1 << AVG_SHIFT) / AVG_COUNT);
  localparam int                     AVG_PROD_W  = SUM_W + AVG_RECIP_W;
  localparam int                     AVG_BACK_W  = SUM_W + CNT_W;
  localparam logic [CNT_W-1:0]       AVG_DIV     = CNT_W'(AVG_COUNT);

  // Temperature and control widths
  localparam int TEMP_PROD_W = SUM_W + TEMP_SCALE_W;
  localparam int TEMP_FULL_W = TEMP_PROD_W - TEMP_SHIFT;
  localparam int ERR_W       = TEMP_FULL_W + 2;
  localparam int ADJ_W       = ERR_W + GAIN_W + 1;

  localparam logic signed [ADJ_W-1:0] T_OFF = ADJ_W'(DUTY_OFF_T);
  localparam logic signed [ADJ_W-1:0] T_MID = ADJ_W'(DUTY_MID_T);
  localparam logic signed [ADJ_W-1:0] T_LOW = ADJ_W'(DUTY_LOW_T);

  // Segment divide by 100 or 10, reciprocal multiply plus one correction
  localparam int                 X_W         = 13;
  localparam int                 DIV_SHIFT   = 16;
  localparam int                 DIV_RECIP_W = 13;
  localparam logic [DIV_RECIP_W-1:0] MID_RECIP = DIV_RECIP_W'((1 << DIV_SHIFT) / 100);
  localparam logic [DIV_RECIP_W-1:0] LOW_RECIP = DIV_RECIP_W'((1 << DIV_SHIFT) / 10);
  localparam int                 DIV_PROD_W  = X_W + DIV_RECIP_W;
  localparam int                 QD_W        = DIV_PROD_W - DIV_SHIFT;
  localparam int                 QBACK_W     = QD_W + SLOPE_W;
  localparam int                 PCT_W       = 7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG_MUL,
    S_AVG_FIX,
    S_TEMP,
    S_ADJ,
    S_MAP,
    S_DIV,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RGN_OFF,
    RGN_MID,
    RGN_LOW,
    RGN_FULL
  } region_t;

  state_t                   state;
  logic [SUM_W-1:0]         sum_r;
  logic [AVG_PROD_W-1:0]    avg_prod;
  logic [SUM_W-1:0]         avg;
  logic [TEMP_FULL_W-1:0]   temp_full;
  logic signed [ADJ_W-1:0]  adj;
  region_t                  region;
  logic [X_W-1:0]           slope_x;
  logic [DIV_PROD_W-1:0]    div_prod;

  logic [SUM_W-1:0]         avg_est;
  logic [AVG_BACK_W-1:0]    avg_back;
  logic [AVG_BACK_W-1:0]    avg_rem;
  logic [SUM_W-1:0]         avg_next;
  logic [TEMP_PROD_W-1:0]   temp_prod;
  logic signed [ADJ_W-1:0]  goal_s;
  logic signed [ADJ_W-1:0]  gain_s;
  logic signed [ADJ_W-1:0]  err_s;
  logic signed [ADJ_W-1:0]  adj_next;
  region_t                  region_next;
  logic [SLOPE_W-1:0]       t_low;
  logic [X_W-1:0]           slope_x_next;
  logic [DIV_RECIP_W-1:0]   recip_sel;
  logic [QD_W-1:0]          q_est;
  logic [SLOPE_W-1:0]       div_sel;
  logic [QBACK_W-1:0]       q_back;
  logic [QBACK_W-1:0]       q_rem;
  logic [QD_W-1:0]          q_fix;
  logic [QD_W-1:0]          pct_raw;
  logic [PCT_W-1:0]         pct;
  logic                     out_free;

  assign pop_stall = (state != S_IDLE);
  assign out_free  = !result_valid || !result_stall;

  // Average: estimate from the reciprocal product, then fix up by one
  assign avg_est  = avg_prod[AVG_SHIFT +: SUM_W];
  assign avg_back = avg_est * AVG_DIV;
  assign avg_rem  = AVG_BACK_W'(sum_r) - avg_back;
  assign avg_next = avg_est + SUM_W'(avg_rem >= AVG_BACK_W'(AVG_DIV));

  // Degrees from the average
  assign temp_prod = avg * TEMP_SCALE;

  // Proportional correction around the goal
  assign goal_s   = $signed(ADJ_W'(goal_temp));
  assign gain_s   = $signed(ADJ_W'(loop_gain));
  assign err_s    = goal_s - $signed(ADJ_W'(temp_full));
  assign adj_next = gain_s * err_s + goal_s;

  // Classify the corrected temperature and form the segment product
  assign t_low = adj[SLOPE_W-1:0];
  always_comb begin
    if (adj > T_OFF) begin
      region_next = RGN_OFF;
    end else if (adj > T_MID) begin
      region_next = RGN_MID;
    end else if (adj > T_LOW) begin
      region_next = RGN_LOW;
    end else begin
      region_next = RGN_FULL;
    end
  end
  assign slope_x_next = (region_next == RGN_MID) ? X_W'(t_low) * X_W'(MID_SLOPE)
                                                 : X_W'(t_low) * X_W'(LOW_SLOPE);

  // Segment quotient: estimate, then fix up by one
  assign recip_sel = (region == RGN_MID) ? MID_RECIP : LOW_RECIP;
  assign div_sel   = (region == RGN_MID) ? MID_DIV : LOW_DIV;
  assign q_est     = div_prod[DIV_SHIFT +: QD_W];
  assign q_back    = q_est * div_sel;
  assign q_rem     = QBACK_W'(slope_x) - q_back;
  assign q_fix     = q_est + QD_W'(q_rem >= QBACK_W'(div_sel));

  // Duty percent per region, limited to full scale
  always_comb begin
    unique case (region)
      RGN_OFF:  pct_raw = '0;
      RGN_MID:  pct_raw = QD_W'(MID_BASE) - q_fix;
      RGN_LOW:  pct_raw = QD_W'(LOW_BASE) - q_fix;
      RGN_FULL: pct_raw = QD_W'(PCT_MAX);
      default:  pct_raw = '0;
    endcase
    pct = (pct_raw > QD_W'(PCT_MAX)) ? PCT_MAX : pct_raw[PCT_W-1:0];
  end

  // Sequence the update and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      // Drop a taken result unless a new one loads in the same cycle
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop.valid) begin
            sum_r <= pop.sum;
            state <= S_AVG_MUL;
          end
        end
        S_AVG_MUL: begin
          avg_prod <= sum_r * AVG_RECIP;
          state    <= S_AVG_FIX;
        end
        S_AVG_FIX: begin
          avg   <= avg_next;
          state <= S_TEMP;
        end
        S_TEMP: begin
          temp_full <= temp_prod[TEMP_SHIFT +: TEMP_FULL_W];
          state     <= S_ADJ;
        end
        S_ADJ: begin
          adj   <= adj_next;
          state <= S_MAP;
        end
        S_MAP: begin
          region  <= region_next;
          slope_x <= slope_x_next;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_prod <= slope_x * recip_sel;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            result_valid <= 1'b1;
            duty_count   <= DUTY_W'(pct) * DUTY_W'(PCT_SCALE);
            temperature  <= temp_full[TEMP_W-1:0];
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/fan_temperature_control_loop.sv
// ----------------------------------------------------------------------------
// Fan temperature control loop
// Averages temperature samples and maps the corrected temperature to a fan
// PWM compare value.
// ----------------------------------------------------------------------------
// A sample is taken in every cycle while the sum queue has room. The first
// AVG_COUNT samples of a window are summed; the next one is dropped and
// starts an update. The update runs in a sequencer behind a QUEUE_DEPTH-entry
// queue, one step per multiply (average, degrees, correction, segment product,
// segment divide) from leaving the queue to the result register. One result
// (duty percent times ten, and the averaged temperature) comes out per window
// of AVG_COUNT + 1 samples. The user must write goal_temp and loop_gain via the
// config port while no update is pending; the block does not enforce this.
// ----------------------------------------------------------------------------
module fan_temperature_control_loop import ftc_pkg::*; #(
  parameter int AVG_COUNT   = AVG_COUNT_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  logic [ADC_W-1:0]       adc_sample,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [DUTY_W-1:0]      duty_count,
  output logic [TEMP_W-1:0]      temperature
);

  logic [GOAL_W-1:0] goal_temp;
  logic [GAIN_W-1:0] loop_gain;
  sum_item_t         push;
  sum_item_t         pop;
  logic              queue_full;
  logic              pop_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_temp <= GOAL_RESET;
      loop_gain <= GAIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GOAL_TEMP: goal_temp <= cfg_data[GOAL_W-1:0];
        REG_LOOP_GAIN: loop_gain <= cfg_data[GAIN_W-1:0];
        default:       goal_temp <= goal_temp;
      endcase
    end
  end

  ftc_front #(
    .AVG_COUNT (AVG_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .adc_sample   (adc_sample),
    .queue_full   (queue_full),
    .push         (push)
  );

  ftc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (queue_full),
    .pop       (pop),
    .pop_stall (pop_stall)
  );

  ftc_back #(
    .AVG_COUNT (AVG_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .goal_temp    (goal_temp),
    .loop_gain    (loop_gain),
    .pop          (pop),
    .pop_stall    (pop_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .duty_count   (duty_count),
    .temperature  (temperature)
  );

  // Never push a sum into a full queue
  assert property (@(posedge clk) disable iff (rst) push.valid |-> !queue_full)
    else $error("sum pushed into full queue");

  // A pushed sum is waiting in the queue on the next cycle
  assert property (@(posedge clk) disable iff (rst) push.valid |=> pop.valid)
    else $error("pushed sum not visible at queue head");

  // Duty compare value stays within the PWM period
  assert property (@(posedge clk) disable iff (rst)
                   result_valid |-> (duty_count <= DUTY_W'(1000)))
    else $error("duty compare value beyond period");

endmodule

FILE: dv/fan_temperature_control_loop_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fan temperature control loop testbench
// Streams temperature samples through the block in windows and broken runs.
// Random idle gaps and stalls sit on both sides. A long receiver hold-off
// fills the block up. Every duty update is checked against a local model of
// the averaging, the degree conversion, the proportional correction and the
// piecewise duty map.
// ----------------------------------------------------------------------------
module fan_temperature_control_loop_test;
  import ftc_pkg::*;

  localparam int WINDOW_LEN    = AVG_COUNT_DEFAULT;
  localparam int ADC_MAX       = (1 << ADC_W) - 1;
  localparam int DEGREES_MAX   = 329;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 300;

  // Sample content of one averaging window
  typedef enum int {
    MIX_RANDOM,
    MIX_CLUSTER,
    MIX_NEAR_GOAL,
    MIX_EXTREME
  } sample_mix_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [TEMP_W-1:0] degrees;
  } fan_update_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   sample_valid;
  logic                   sample_stall;
  logic [ADC_W-1:0]       adc_sample;
  logic                   result_valid;
  logic                   result_stall;
  logic [DUTY_W-1:0]      duty_count;
  logic [TEMP_W-1:0]      temperature;

  // Local copy of the control state
  logic [GOAL_W-1:0] goal_setting;
  logic [GAIN_W-1:0] gain_setting;
  logic [SUM_W-1:0]  window_sum;
  int                window_fill;
  fan_update_t       pending_updates[$];

  int sample_gap_max     = 0;
  int result_gap_max     = 0;
  int result_hold_cycles = 0;
  int samples_sent       = 0;
  int updates_seen       = 0;
  int settings_written   = 0;
  int mismatch_count     = 0;

  fan_temperature_control_loop uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .adc_sample   (adc_sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .duty_count   (duty_count),
    .temperature  (temperature)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compute the duty update that a finished window sum produces
  function automatic fan_update_t fan_update(input logic [SUM_W-1:0] sum);
    int average;
    int degrees;
    int adjusted;
    int pct;
    fan_update_t upd;
    average  = int'(sum) / WINDOW_LEN;
    degrees  = (average * int'(TEMP_SCALE)) >> TEMP_SHIFT;
    adjusted = int'(gain_setting) * (int'(goal_setting) - degrees) + int'(goal_setting);
    if (adjusted > DUTY_OFF_T) begin
      pct = 0;
    end else if (adjusted > DUTY_MID_T) begin
      pct = (adjusted * -int'(MID_SLOPE)) / int'(MID_DIV) + int'(MID_BASE);
    end else if (adjusted > DUTY_LOW_T) begin
      pct = (adjusted * -int'(LOW_SLOPE)) / int'(LOW_DIV) + int'(LOW_BASE);
    end else begin
      pct = int'(PCT_MAX);
    end
    if (pct < 0) pct = 0;
    if (pct > int'(PCT_MAX)) pct = int'(PCT_MAX);
    upd.duty    = DUTY_W'(pct * int'(PCT_SCALE));
    upd.degrees = TEMP_W'(degrees);
    return upd;
  endfunction

  // Goal temperature: extremes, duty map breakpoints, or a typical range
  function automatic logic [CFG_DATA_W-1:0] pick_goal();
    case ($urandom_range(0, 5))
      0: pick_goal = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      1: begin
        case ($urandom_range(0, 5))
          0: pick_goal = CFG_DATA_W'(DUTY_LOW_T);
          1: pick_goal = CFG_DATA_W'(DUTY_LOW_T + 1);
          2: pick_goal = CFG_DATA_W'(DUTY_MID_T);
          3: pick_goal = CFG_DATA_W'(DUTY_MID_T + 1);
          4: pick_goal = CFG_DATA_W'(DUTY_OFF_T);
          default: pick_goal = CFG_DATA_W'(DUTY_OFF_T + 1);
        endcase
      end
      default: pick_goal = CFG_DATA_W'($urandom_range(15, 90));
    endcase
  endfunction

  // Gain in the low nibble, junk in the bits above it
  function automatic logic [CFG_DATA_W-1:0] pick_gain_data();
    logic [GAIN_W-1:0] gain;
    case ($urandom_range(0, 4))
      0: gain = '0;
      1: gain = '1;
      default: gain = GAIN_W'($urandom_range(0, 15));
    endcase
    pick_gain_data = {4'($urandom_range(0, 15)), gain};
  endfunction

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Offer one sample, hold it until accepted, then advance the model
  task automatic send_sample(input logic [ADC_W-1:0] value);
    int gap;
    gap = $urandom_range(0, sample_gap_max);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    adc_sample   <= value;
    do @(posedge clk); while (sample_stall);
    samples_sent++;
    if (window_fill < WINDOW_LEN) begin
      window_sum  = window_sum + value;
      window_fill = window_fill + 1;
    end else begin
      pending_updates.push_back(fan_update(window_sum));
      window_sum  = '0;
      window_fill = 0;
    end
  endtask

  // Pause the sender until every expected update is out and the block is quiet
  task automatic drain_updates();
    sample_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges
  task automatic write_settings(input logic [CFG_DATA_W-1:0] goal_data,
                                input logic [CFG_DATA_W-1:0] gain_data);
    cfg_write <= 1'b1;
    cfg_index <= REG_GOAL_TEMP;
    cfg_data  <= goal_data;
    @(posedge clk);
    cfg_index <= REG_LOOP_GAIN;
    cfg_data  <= gain_data;
    @(posedge clk);
    cfg_write    <= 1'b0;
    goal_setting = goal_data[GOAL_W-1:0];
    gain_setting = gain_data[GAIN_W-1:0];
    settings_written++;
  endtask

  // Send one full window followed by its trigger sample
  task automatic send_window(input sample_mix_t mix);
    int deg;
    int near;
    int base;
    int raw;
    int i;
    logic [ADC_W-1:0] value;
    deg = int'(goal_setting) + int'($urandom_range(0, 16)) - 6;
    if (deg < 0) deg = 0;
    if (deg > DEGREES_MAX) deg = DEGREES_MAX;
    near = (deg * 1024 + DEGREES_MAX) / int'(TEMP_SCALE);
    base = $urandom_range(0, ADC_MAX);
    for (i = 0; i < WINDOW_LEN; i++) begin
      case (mix)
        MIX_RANDOM:    raw = $urandom_range(0, ADC_MAX);
        MIX_CLUSTER:   raw = base + int'($urandom_range(0, 15));
        MIX_NEAR_GOAL: raw = near + int'($urandom_range(0, 3));
        default:       raw = $urandom_range(0, 1) ? ADC_MAX : 0;
      endcase
      value = (raw > ADC_MAX) ? ADC_W'(ADC_MAX) : raw[ADC_W-1:0];
      send_sample(value);
    end
    // Trigger value carries no weight
    send_sample(ADC_W'($urandom_range(0, ADC_MAX)));
  endtask

  // Coldest and hottest windows at reset settings; trigger opposite to data
  task automatic test_reset_extremes();
    int i;
    sample_gap_max = 0;
    result_gap_max = 0;
    for (i = 0; i < WINDOW_LEN; i++) send_sample('0);
    send_sample('1);
    for (i = 0; i < WINDOW_LEN; i++) send_sample('1);
    send_sample('0);
    drain_updates();
  endtask

  // Random windows over phases of settings, extremes first
  task automatic test_random_windows(input int windows);
    int w;
    int roll;
    sample_mix_t mix;
    for (w = 0; w < windows; w++) begin
      if (w % 3 == 0) begin
        drain_updates();
        case (w / 3)
          0: write_settings(8'hFF, 8'hFF);
          1: write_settings(8'h00, 8'hF0);
          default: write_settings(pick_goal(), pick_gain_data());
        endcase
        sample_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
        result_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
      end
      roll = $urandom_range(0, 9);
      if (roll < 5) mix = MIX_NEAR_GOAL;
      else if (roll < 7) mix = MIX_CLUSTER;
      else if (roll < 9) mix = MIX_RANDOM;
      else mix = MIX_EXTREME;
      send_window(mix);
    end
    drain_updates();
  endtask

  // Hold the receiver off while the sender keeps pushing full windows
  task automatic test_backpressure();
    int w;
    write_settings(pick_goal(), pick_gain_data());
    sample_gap_max     = 0;
    result_gap_max     = 2;
    result_hold_cycles = LONG_HOLD;
    for (w = 0; w < 8; w++) send_window(MIX_NEAR_GOAL);
    drain_updates();
  endtask

  // Runs of arbitrary length, so settings change in the middle of a window
  task automatic test_broken_windows();
    int run;
    int len;
    int i;
    for (run = 0; run < 6; run++) begin
      sample_gap_max = $urandom_range(0, 1) * 4;
      result_gap_max = $urandom_range(0, 1) * 4;
      len = $urandom_range(1, 2 * WINDOW_LEN + 1);
      for (i = 0; i < len; i++) send_sample(ADC_W'($urandom_range(0, ADC_MAX)));
      drain_updates();
      write_settings(pick_goal(), pick_gain_data());
    end
  endtask

  // Accept updates with random stalls and check each against the model
  initial begin : update_receiver
    int hold;
    fan_update_t want;
    result_stall <= 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = $urandom_range(0, result_gap_max);
      if (result_hold_cycles > 0) begin
        hold = result_hold_cycles;
        result_hold_cycles = 0;
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      updates_seen++;
      if (pending_updates.size() == 0) begin
        flag_mismatch($sformatf("update with none pending: duty %0d temperature %0d",
                                duty_count, temperature));
      end else begin
        want = pending_updates.pop_front();
        if (duty_count !== want.duty)
          flag_mismatch($sformatf("duty_count %0d, model %0d", duty_count, want.duty));
        if (temperature !== want.degrees)
          flag_mismatch($sformatf("temperature %0d, model %0d", temperature, want.degrees));
      end
    end
  end

  // Reset, run each test in turn, settle and report
  initial begin : test_sequence
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= REG_GOAL_TEMP;
    cfg_data     <= '0;
    sample_valid <= 1'b0;
    adc_sample   <= '0;
    goal_setting = GOAL_RESET;
    gain_setting = GAIN_RESET;
    window_sum   = '0;
    window_fill  = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_extremes();
    test_random_windows(27);
    test_backpressure();
    test_broken_windows();
    drain_updates();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d samples, %0d duty updates and %0d register settings",
             samples_sent, updates_seen, settings_written);
    $display("Included a %0d-cycle receiver hold-off and runs broken mid-window",
             LONG_HOLD);
    if (mismatch_count == 0) begin
      $display("fan_temperature_control_loop test passed");
    end else begin
      $display("fan_temperature_control_loop test failed");
    end
    $finish;
  end

  // Watchdog: end the run with a failure if it runs past its time limit
  initial begin : watchdog
    #1000000;
    $display("fan_temperature_control_loop test failed");
    $finish;
  end

endmodule

FILE: fan_temperature_control_loop.f
rtl/core/ftc_pkg.sv
rtl/core/ftc_front.sv
rtl/core/ftc_queue.sv
rtl/core/ftc_back.sv
rtl/core/fan_temperature_control_loop.sv
dv/fan_temperature_control_loop_test.sv
